FILE: hdl/piecewise_loss_gradient_unit_assert.svh
// Assertion macros shared by the loss gradient RTL.
`ifndef PIECEWISE_LOSS_GRADIENT_UNIT_ASSERT_SVH
`define PIECEWISE_LOSS_GRADIENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PLGU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/plgu_pkg.sv
// Package: loss kinds, register indexes and saturation helpers for the loss gradient unit.
package plgu_pkg;

    typedef enum logic [2:0] {
        KIND_CLIP      = 3'd0,
        KIND_SQUARED   = 3'd1,
        KIND_HINGE     = 3'd2,
        KIND_QUANTILE  = 3'd3,
        KIND_EXPECTILE = 3'd4
    } t_loss_kind;

    typedef enum logic [1:0] {
        CFG_LOSS_KIND = 2'd0,
        CFG_MIN_LABEL = 2'd1,
        CFG_MAX_LABEL = 2'd2,
        CFG_ASYMMETRY = 2'd3
    } t_cfg_index;

    typedef logic signed [63:0] t_wide;

    localparam t_wide SAT_MAX = 64'sd2147483647;
    localparam t_wide SAT_MIN = -64'sd2147483648;
    localparam logic [16:0] A_ONE = 17'd65536;

    function automatic logic signed [31:0] sat_s32(input t_wide v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] sat_u31(input t_wide v);
        logic [30:0] r;
        if (v < 64'sd0) begin
            r = 31'd0;
        end else if (v > SAT_MAX) begin
            r = 31'h7FFF_FFFF;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    // magnitude below 2^62 plus sign to two's complement
    function automatic t_wide apply_sign(input logic [63:0] mag, input logic neg);
        t_wide m;
        m = $signed(mag);
        return neg ? -m : m;
    endfunction

endpackage

FILE: hdl/piecewise_loss_gradient_unit.sv
// Loss gradient unit: five-stage pipeline computing loss, derivatives and step per word.
//
// Input channel: i_in_valid / o_in_ready carry one word (prediction, label,
// step_scale; prediction and label signed, step_scale unsigned; fixed point with
// FRAC_BITS fraction bits). Output channel: o_out_valid / i_out_ready carry one
// result word (loss, first and second derivative, squared gradient, plain step,
// hinge label warning). One word per cycle is accepted and delivered when the
// receiver keeps i_out_ready high. Stage two holds the first bank of multipliers,
// stage four the second bank used by the expectile kind; stages one, three and
// five do the differences, shifts, sums and saturation.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// o_in_ready drops in the same cycle; nothing is dropped or repeated.
// Configuration (loss kind, label bounds, asymmetry) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data and takes effect at once; write it only
// while the pipeline is empty.
// Synchronous active-low reset empties the pipeline and restores the register
// defaults: clipped squared kind, bounds 0 and 1.0, asymmetry 0.5.
`include "piecewise_loss_gradient_unit_assert.svh"

module piecewise_loss_gradient_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_prediction,
    input  logic signed [31:0] i_label,
    input  logic [30:0]        i_step_scale,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_loss_value,
    output logic signed [31:0] o_first_deriv,
    output logic signed [31:0] o_second_deriv,
    output logic [30:0]        o_grad_squared,
    output logic signed [31:0] o_plain_step,
    output logic               o_label_warning
);

    localparam logic signed [31:0] Q_ONE32  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] Q_MONE32 = -Q_ONE32;
    localparam plgu_pkg::t_wide    Q_ONE    = 64'sd1 <<< FRAC_BITS;
    localparam plgu_pkg::t_wide    Q_TWO    = 64'sd2 <<< FRAC_BITS;

    // ---------------- configuration ----------------
    logic [2:0]         r_kind;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic [16:0]        r_asym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= plgu_pkg::KIND_CLIP;
            r_min  <= 32'sd0;
            r_max  <= Q_ONE32;
            r_asym <= 17'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plgu_pkg::CFG_LOSS_KIND: r_kind <= i_cfg_data[2:0];
                plgu_pkg::CFG_MIN_LABEL: r_min  <= i_cfg_data;
                plgu_pkg::CFG_MAX_LABEL: r_max  <= i_cfg_data;
                plgu_pkg::CFG_ASYMMETRY: r_asym <= i_cfg_data[16:0];
                default: r_kind <= r_kind;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en;

    assign w_en        = !r_v5 || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // ---------------- stage 1: differences, bounds, selects ----------------
    logic signed [32:0]     c1_e, c1_t, c1_d, c1_diff;
    logic signed [31:0]     c1_pc;
    logic                   c1_inside, c1_below, c1_teq, c1_epos;
    logic [16:0]            c1_a, c1_w, c1_aq;
    logic [16+FRAC_BITS:0]  c1_dq_full;
    logic [32:0]            c1_emag, c1_tmag, c1_dmag, c1_tq;
    logic [31:0]            c1_ymag, c1_pmag;
    logic signed [33:0]     c1_cd1;
    logic [33:0]            c1_cd1mag;

    always_comb begin
        c1_e      = {i_label[31], i_label} - {i_prediction[31], i_prediction};
        c1_inside = (i_prediction <= r_max) && (i_prediction >= r_min);
        c1_below  = i_prediction < r_min;
        c1_t      = c1_below ? ({i_label[31], i_label} - {r_min[31], r_min})
                             : ({r_max[31], r_max} - {i_label[31], i_label});
        c1_d      = c1_below ? ({r_min[31], r_min} - {i_prediction[31], i_prediction})
                             : ({i_prediction[31], i_prediction} - {r_max[31], r_max});
        c1_teq    = c1_below ? (i_label == r_min) : (i_label == r_max);
        c1_pc     = c1_below ? r_min : ((i_prediction > r_max) ? r_max : i_prediction);
        c1_diff   = {c1_pc[31], c1_pc} - {i_label[31], i_label};
        c1_cd1    = {c1_diff, 1'b0};
        c1_cd1mag = c1_cd1[33] ? 34'(-c1_cd1) : 34'(c1_cd1);
        c1_emag   = c1_e[32] ? 33'(-c1_e) : 33'(c1_e);
        c1_tmag   = c1_t[32] ? 33'(-c1_t) : 33'(c1_t);
        c1_dmag   = c1_d[32] ? 33'(-c1_d) : 33'(c1_d);
        c1_ymag   = i_label[31] ? 32'(-i_label) : 32'(i_label);
        c1_pmag   = i_prediction[31] ? 32'(-i_prediction) : 32'(i_prediction);
        c1_a      = (r_asym > plgu_pkg::A_ONE) ? plgu_pkg::A_ONE : r_asym;
        c1_epos   = !c1_e[32] && (c1_e != 33'sd0);
        c1_w      = c1_e[32] ? c1_a : (plgu_pkg::A_ONE - c1_a);
        c1_aq     = c1_epos ? c1_a : (plgu_pkg::A_ONE - c1_a);
        c1_dq_full = {c1_aq, {FRAC_BITS{1'b0}}} >> 16;
        case (r_kind)
            plgu_pkg::KIND_HINGE:    c1_tq = {1'b0, c1_ymag};
            plgu_pkg::KIND_QUANTILE: c1_tq = 33'(c1_dq_full[FRAC_BITS:0]);
            default:                 c1_tq = c1_inside ? c1_emag : c1_tmag;
        endcase
    end

    logic [2:0]           r1_kind;
    logic signed [32:0]   r1_e;
    logic [32:0]          r1_emag, r1_tq, r1_tmag, r1_dmag;
    logic                 r1_tneg, r1_inside, r1_teq, r1_epos, r1_warn;
    logic signed [33:0]   r1_cd1;
    logic [33:0]          r1_cd1mag;
    logic [16:0]          r1_w, r1_aq;
    logic [FRAC_BITS:0]   r1_dq;
    logic [31:0]          r1_ymag, r1_pmag;
    logic signed [31:0]   r1_y;
    logic                 r1_pneg;
    logic [30:0]          r1_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind   <= r_kind;
            r1_e      <= c1_e;
            r1_emag   <= c1_emag;
            r1_tq     <= c1_tq;
            r1_tmag   <= c1_tmag;
            r1_dmag   <= c1_dmag;
            r1_tneg   <= c1_t[32];
            r1_inside <= c1_inside;
            r1_teq    <= c1_teq;
            r1_epos   <= c1_epos;
            r1_warn   <= (r_kind == plgu_pkg::KIND_HINGE)
                         && (i_label != Q_ONE32) && (i_label != Q_MONE32);
            r1_cd1    <= c1_cd1;
            r1_cd1mag <= c1_cd1mag;
            r1_w      <= c1_w;
            r1_aq     <= c1_aq;
            r1_dq     <= c1_dq_full[FRAC_BITS:0];
            r1_ymag   <= c1_ymag;
            r1_pmag   <= c1_pmag;
            r1_y      <= i_label;
            r1_pneg   <= i_prediction[31];
            r1_s      <= i_step_scale;
        end
    end

    // ---------------- stage 2: first multiplier bank ----------------
    logic [65:0] m2_ee, m2_tq, m2_td;
    logic [63:0] m2_es, m2_yp;
    logic [62:0] m2_ys;
    logic [49:0] m2_ae;
    logic [47:0] m2_qs, m2_ws;
    logic [33:0] m2_ww;
    logic [50:0] m2_dw;

    assign m2_ee = r1_emag * r1_emag;
    assign m2_tq = r1_tq * r1_tq;
    assign m2_td = r1_tmag * r1_dmag;
    assign m2_es = r1_emag * r1_s;
    assign m2_yp = r1_ymag * r1_pmag;
    assign m2_ys = r1_ymag * r1_s;
    assign m2_ae = r1_aq * r1_emag;
    assign m2_qs = r1_aq * r1_s;
    assign m2_ws = r1_w * r1_s;
    assign m2_ww = r1_w * r1_w;
    assign m2_dw = r1_cd1mag * r1_w;

    logic [2:0]          r2_kind;
    logic [64:0]         r2_ee, r2_tq, r2_td;
    logic [63:0]         r2_es;
    logic [62:0]         r2_yp, r2_ys;
    logic [49:0]         r2_ae;
    logic [47:0]         r2_qs, r2_ws;
    logic [32:0]         r2_ww;
    logic [50:0]         r2_dw;
    logic signed [32:0]  r2_e;
    logic [32:0]         r2_emag;
    logic                r2_tneg, r2_inside, r2_teq, r2_epos, r2_warn, r2_pneg;
    logic signed [33:0]  r2_cd1;
    logic [16:0]         r2_w;
    logic [FRAC_BITS:0]  r2_dq;
    logic signed [31:0]  r2_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_kind   <= r1_kind;
            r2_ee     <= m2_ee[64:0];
            r2_tq     <= m2_tq[64:0];
            r2_td     <= m2_td[64:0];
            r2_es     <= m2_es;
            r2_yp     <= m2_yp[62:0];
            r2_ys     <= m2_ys;
            r2_ae     <= m2_ae;
            r2_qs     <= m2_qs;
            r2_ws     <= m2_ws;
            r2_ww     <= m2_ww[32:0];
            r2_dw     <= m2_dw;
            r2_e      <= r1_e;
            r2_emag   <= r1_emag;
            r2_tneg   <= r1_tneg;
            r2_inside <= r1_inside;
            r2_teq    <= r1_teq;
            r2_epos   <= r1_epos;
            r2_warn   <= r1_warn;
            r2_pneg   <= r1_pneg;
            r2_cd1    <= r1_cd1;
            r2_w      <= r1_w;
            r2_dq     <= r1_dq;
            r2_y      <= r1_y;
        end
    end

    // ---------------- stage 3: shifts, sums, per-kind select ----------------
    logic [64:0]           c3_ee_f, c3_ee_g, c3_tq_f, c3_td_h;
    logic [17+FRAC_BITS:0] c3_d2w;
    plgu_pkg::t_wide       c3_cl, c3_yp, c3_dq, c3_e64;
    plgu_pkg::t_wide       c3_loss, c3_d1, c3_d2, c3_gsq, c3_step;
    logic                  c3_hinge_on, c3_eneg;

    always_comb begin
        c3_ee_f = r2_ee >> FRAC_BITS;
        c3_ee_g = r2_ee >> (FRAC_BITS - 2);
        c3_tq_f = r2_tq >> FRAC_BITS;
        c3_td_h = r2_td >> (FRAC_BITS - 1);
        c3_d2w  = {r2_w, {(FRAC_BITS + 1){1'b0}}} >> 16;
        c3_eneg = r2_e[32];
        c3_e64  = 64'(r2_e);
        c3_dq   = $signed(64'(r2_dq));
        if (r2_inside) begin
            c3_cl = $signed(c3_tq_f[63:0]);
        end else if (r2_teq) begin
            c3_cl = 64'sd0;
        end else begin
            c3_cl = $signed(c3_tq_f[63:0])
                    + plgu_pkg::apply_sign(c3_td_h[63:0], r2_tneg);
        end
        c3_yp       = plgu_pkg::apply_sign(64'(r2_yp >> FRAC_BITS), r2_y[31] ^ r2_pneg);
        c3_hinge_on = c3_yp < Q_ONE;

        c3_loss = 64'sd0;
        c3_d1   = 64'sd0;
        c3_d2   = 64'sd0;
        c3_gsq  = 64'sd0;
        c3_step = 64'sd0;
        case (r2_kind)
            plgu_pkg::KIND_CLIP: begin
                c3_loss = c3_cl;
                c3_d1   = 64'(r2_cd1);
                c3_d2   = r2_inside ? Q_TWO : 64'sd0;
                c3_gsq  = $signed(c3_ee_g[63:0]);
                c3_step = plgu_pkg::apply_sign(64'(r2_es >> (FRAC_BITS - 1)), c3_eneg);
            end
            plgu_pkg::KIND_SQUARED: begin
                c3_loss = $signed(c3_ee_f[63:0]);
                c3_d1   = -(c3_e64 <<< 1);
                c3_d2   = Q_TWO;
                c3_gsq  = $signed(c3_ee_g[63:0]);
                c3_step = plgu_pkg::apply_sign(64'(r2_es >> (FRAC_BITS - 1)), c3_eneg);
            end
            plgu_pkg::KIND_HINGE: begin
                if (c3_hinge_on) begin
                    c3_loss = Q_ONE - c3_yp;
                    c3_d1   = -64'(r2_y);
                    c3_gsq  = $signed(c3_tq_f[63:0]);
                    c3_step = plgu_pkg::apply_sign(64'(r2_ys >> FRAC_BITS), r2_y[31]);
                end
            end
            plgu_pkg::KIND_QUANTILE: begin
                c3_loss = $signed(64'(r2_ae >> 16));
                if (r2_epos) begin
                    c3_d1   = -c3_dq;
                    c3_gsq  = $signed(c3_tq_f[63:0]);
                    c3_step = $signed(64'(r2_qs >> 16));
                end else if (c3_eneg) begin
                    c3_d1   = c3_dq;
                    c3_gsq  = $signed(c3_tq_f[63:0]);
                    c3_step = -$signed(64'(r2_qs >> 16));
                end
            end
            plgu_pkg::KIND_EXPECTILE: begin
                c3_d1 = plgu_pkg::apply_sign(64'(r2_dw >> 16), r2_cd1[33]);
                c3_d2 = r2_inside ? $signed(64'(c3_d2w)) : 64'sd0;
            end
            default: c3_loss = 64'sd0;
        endcase
    end

    logic [2:0]        r3_kind;
    plgu_pkg::t_wide   r3_loss, r3_d1, r3_d2, r3_gsq, r3_step;
    logic [58:0]       r3_clmag;
    logic              r3_clneg;
    logic [58:0]       r3_g1;
    logic [31:0]       r3_sw;
    logic [32:0]       r3_ww;
    logic [16:0]       r3_w;
    logic [32:0]       r3_emag;
    logic              r3_eneg, r3_warn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_kind  <= r2_kind;
            r3_loss  <= c3_loss;
            r3_d1    <= c3_d1;
            r3_d2    <= c3_d2;
            r3_gsq   <= c3_gsq;
            r3_step  <= c3_step;
            r3_clneg <= c3_cl[63];
            r3_clmag <= c3_cl[63] ? 59'(-c3_cl) : 59'(c3_cl);
            r3_g1    <= c3_ee_g[58:0];
            r3_sw    <= r2_ws[47:16];
            r3_ww    <= r2_ww;
            r3_w     <= r2_w;
            r3_emag  <= r2_emag;
            r3_eneg  <= c3_eneg;
            r3_warn  <= r2_warn;
        end
    end

    // ---------------- stage 4: expectile multiplier bank ----------------
    logic [75:0] m4_clw;
    logic [62:0] m4_gh;
    logic [61:0] m4_gl;
    logic [64:0] m4_esw;

    assign m4_clw = r3_clmag * r3_w;
    assign m4_gh  = r3_g1[58:29] * r3_ww;
    assign m4_gl  = r3_g1[28:0] * r3_ww;
    assign m4_esw = r3_emag * r3_sw;

    logic [2:0]        r4_kind;
    plgu_pkg::t_wide   r4_loss, r4_d1, r4_d2, r4_gsq, r4_step;
    logic [59:0]       r4_clw;
    logic              r4_clneg, r4_eneg, r4_warn;
    logic [62:0]       r4_gh;
    logic [61:0]       r4_gl;
    logic [64:0]       r4_esw;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_kind  <= r3_kind;
            r4_loss  <= r3_loss;
            r4_d1    <= r3_d1;
            r4_d2    <= r3_d2;
            r4_gsq   <= r3_gsq;
            r4_step  <= r3_step;
            r4_clw   <= m4_clw[75:16];
            r4_clneg <= r3_clneg;
            r4_gh    <= m4_gh;
            r4_gl    <= m4_gl;
            r4_esw   <= m4_esw;
            r4_eneg  <= r3_eneg;
            r4_warn  <= r3_warn;
        end
    end

    // ---------------- stage 5: expectile finish, saturation ----------------
    logic [91:0]      c5_gsum, c5_gsh;
    logic [64:0]      c5_esh;
    plgu_pkg::t_wide  c5_loss, c5_gsq, c5_step;

    always_comb begin
        c5_gsum = {r4_gh, 29'd0} + 92'(r4_gl);
        c5_gsh  = c5_gsum >> 32;
        c5_esh  = r4_esw >> (FRAC_BITS - 1);
        if (r4_kind == plgu_pkg::KIND_EXPECTILE) begin
            c5_loss = plgu_pkg::apply_sign(64'(r4_clw), r4_clneg);
            c5_gsq  = $signed(c5_gsh[63:0]);
            c5_step = plgu_pkg::apply_sign(c5_esh[63:0], r4_eneg);
        end else begin
            c5_loss = r4_loss;
            c5_gsq  = r4_gsq;
            c5_step = r4_step;
        end
    end

    logic signed [31:0] r_loss, r_d1, r_d2, r_step;
    logic [30:0]        r_gsq;
    logic               r_warn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_loss <= plgu_pkg::sat_s32(c5_loss);
            r_d1   <= plgu_pkg::sat_s32(r4_d1);
            r_d2   <= plgu_pkg::sat_s32(r4_d2);
            r_gsq  <= plgu_pkg::sat_u31(c5_gsq);
            r_step <= plgu_pkg::sat_s32(c5_step);
            r_warn <= r4_warn;
        end
    end

    assign o_loss_value    = r_loss;
    assign o_first_deriv   = r_d1;
    assign o_second_deriv  = r_d2;
    assign o_grad_squared  = r_gsq;
    assign o_plain_step    = r_step;
    assign o_label_warning = r_warn;

    // ---------------- checks ----------------
    `PLGU_ASSERT_IMP(a_stall_freezes, i_clk, i_rst_n, r_v5 && !i_out_ready, !o_in_ready, "input taken while output stalled")
    `PLGU_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v1, "accepted word lost at stage one")
    `PLGU_ASSERT_IMP(a_warn_hinge, i_clk, i_rst_n, r_v3 && r3_warn, r3_kind == plgu_pkg::KIND_HINGE, "label warning outside hinge kind")
    `PLGU_ASSERT_IMP(a_d2_nonneg, i_clk, i_rst_n, o_out_valid, !o_second_deriv[31], "negative second derivative")

endmodule
